/* rtl/cfss_pkg.sv */
// Shared types and constants for the code fence stream splitter.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package cfss_pkg;

	localparam int FENCE_MAX_DEF = 8;

	localparam int BYTE_W     = 8;
	localparam int REQ_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;
	localparam int LEN_W      = 4;
	// Counts up to FENCE_MAX + 1, which is at most nine.
	localparam int CNT_W      = 4;

	localparam logic [REQ_W-1:0] REQ_DATA  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_CHUNK = 2'd1;
	localparam logic [REQ_W-1:0] REQ_DONE  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_START_FENCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_LEN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_END_FENCE   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_END_LEN     = 2'd3;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              has_byte;
		logic              seg_kind;
		logic              seg_end;
		logic              stream_done;
		logic              last;
	} res_t;

	localparam logic SEG_NORMAL = 1'b0;
	localparam logic SEG_TOOL   = 1'b1;

endpackage

/* rtl/cfss_win_cell.sv */
// One byte cell of the recent-byte window, compared against both fences.
// Depends on cfss_pkg.
`timescale 1ns / 1ps

module cfss_win_cell #(
	parameter int FENCE_MAX = cfss_pkg::FENCE_MAX_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                shift,
	input  logic [cfss_pkg::BYTE_W-1:0]         byte_in,
	input  logic [cfss_pkg::CFG_DATA_W-1:0]     start_fence,
	input  logic [cfss_pkg::CFG_DATA_W-1:0]     end_fence,
	output logic [cfss_pkg::BYTE_W-1:0]         byte_q,
	output logic [FENCE_MAX-1:0]                eq_start,
	output logic [FENCE_MAX-1:0]                eq_end
);
	import cfss_pkg::*;

	// The compares look at the byte this cell will hold after the shift.
	always_comb begin
		for (int q = 0; q < FENCE_MAX; q++) begin
			eq_start[q] = (byte_in == start_fence[BYTE_W*q +: BYTE_W]);
			eq_end[q]   = (byte_in == end_fence[BYTE_W*q +: BYTE_W]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (shift) begin
			byte_q <= byte_in;
		end
	end

endmodule

/* rtl/cfss_out_cell.sv */
// One slot of the result chain: loads in parallel, shifts toward the output.
// Depends on cfss_pkg.
`timescale 1ns / 1ps

module cfss_out_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  logic           shift,
	input  logic           ld_v,
	input  cfss_pkg::res_t ld_d,
	input  logic           nb_v,
	input  cfss_pkg::res_t nb_d,
	output logic           v_q,
	output cfss_pkg::res_t d_q
);
	import cfss_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (load) begin
			v_q <= ld_v;
		end else if (shift) begin
			v_q <= nb_v;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			d_q <= ld_d;
		end else if (shift) begin
			d_q <= nb_d;
		end
	end

endmodule

/* rtl/code_fence_stream_splitter_unit.sv */
// Code fence stream splitter, top level; uses cfss_pkg, cfss_win_cell, cfss_out_cell.
// Results are registered: each appears on the output in the cycle after its request is accepted.
// Throughput: while res_ready is high, a request that yields one result is taken
// every cycle; one that yields several holds the result chain, which sends one
// result per cycle, and the next request is taken in the cycle the last leaves.
// Reset: arst_n clears the mode, counters and chain; registers return to defaults.
`timescale 1ns / 1ps

module code_fence_stream_splitter_unit #(
	parameter int FENCE_MAX = cfss_pkg::FENCE_MAX_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [cfss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cfss_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  logic [cfss_pkg::REQ_W-1:0]      req_type,
	input  logic [cfss_pkg::BYTE_W-1:0]     data_byte,
	output logic                            res_valid,
	input  logic                            res_ready,
	output logic [cfss_pkg::BYTE_W-1:0]     out_byte,
	output logic                            has_byte,
	output logic                            seg_kind,
	output logic                            seg_end,
	output logic                            stream_done,
	output logic                            last
);
	import cfss_pkg::*;

	localparam int NCELL = FENCE_MAX + 1;
	localparam logic [CNT_W-1:0] FMAX = CNT_W'(FENCE_MAX);
	localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

	// Configuration registers.
	logic [CFG_DATA_W-1:0] start_fence_q, end_fence_q;
	logic [LEN_W-1:0]      start_len_q, end_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_fence_q <= '0;
			start_len_q   <= LEN_W'(1);
			end_fence_q   <= '0;
			end_len_q     <= LEN_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_FENCE: start_fence_q <= cfg_data;
				REG_START_LEN:   start_len_q   <= cfg_data[LEN_W-1:0];
				REG_END_FENCE:   end_fence_q   <= cfg_data;
				REG_END_LEN:     end_len_q     <= cfg_data[LEN_W-1:0];
			endcase
		end
	end

	logic [CNT_W-1:0] slen, elen;

	always_comb begin
		if (start_len_q == '0) begin
			slen = ONE;
		end else if (CNT_W'(start_len_q) > FMAX) begin
			slen = FMAX;
		end else begin
			slen = CNT_W'(start_len_q);
		end
		if (end_len_q == '0) begin
			elen = ONE;
		end else if (CNT_W'(end_len_q) > FMAX) begin
			elen = FMAX;
		end else begin
			elen = CNT_W'(end_len_q);
		end
	end

	// Handshake and control state.
	logic             req_acc, res_pop;
	logic             in_tool_q, in_tool_d;
	logic             nopen_q, nopen_d;
	logic [CNT_W-1:0] held_q, held_d;
	logic [CNT_W-1:0] emc_q, emc_d;
	logic             cell_v [NCELL];
	res_t             cell_d [NCELL];

	assign res_pop   = cell_v[0] && res_ready;
	assign req_ready = !cell_v[1] && (!cell_v[0] || res_ready);
	assign req_acc   = req_valid && req_ready;

	// Window cells; cell 0 holds the newest byte.
	logic [BYTE_W-1:0]    win_in [FENCE_MAX];
	logic [BYTE_W-1:0]    win_q  [FENCE_MAX];
	logic [FENCE_MAX-1:0] eq_s   [FENCE_MAX];
	logic [FENCE_MAX-1:0] eq_e   [FENCE_MAX];
	logic                 win_shift;

	assign win_shift = req_acc && (req_type == REQ_DATA);

	for (genvar p = 0; p < FENCE_MAX; p++) begin : g_win
		if (p == 0) begin : g_head
			assign win_in[p] = data_byte;
		end else begin : g_body
			assign win_in[p] = win_q[p-1];
		end
		cfss_win_cell #(
			.FENCE_MAX (FENCE_MAX)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.shift       (win_shift),
			.byte_in     (win_in[p]),
			.start_fence (start_fence_q),
			.end_fence   (end_fence_q),
			.byte_q      (win_q[p]),
			.eq_start    (eq_s[p]),
			.eq_end      (eq_e[p])
		);
	end

	logic [FENCE_MAX*BYTE_W-1:0] new_vec, cur_vec;

	always_comb begin
		for (int p = 0; p < FENCE_MAX; p++) begin
			new_vec[BYTE_W*p +: BYTE_W] = win_in[p];
			cur_vec[BYTE_W*p +: BYTE_W] = win_q[p];
		end
	end

	function automatic logic [BYTE_W-1:0] pick(input logic [FENCE_MAX*BYTE_W-1:0] v,
	                                           input logic [CNT_W-1:0] idx);
		logic [BYTE_W-1:0] r;
		r = '0;
		for (int p = 0; p < FENCE_MAX; p++) begin
			if (CNT_W'(p) == idx) begin
				r = v[BYTE_W*p +: BYTE_W];
			end
		end
		return r;
	endfunction

	// Bit L-1 is set when the newest L bytes equal the first L fence bytes.
	logic [FENCE_MAX-1:0] ms, me;

	always_comb begin
		for (int l = 1; l <= FENCE_MAX; l++) begin
			ms[l-1] = 1'b1;
			me[l-1] = 1'b1;
			for (int i = 0; i < l; i++) begin
				ms[l-1] = ms[l-1] & eq_s[l-1-i][i];
				me[l-1] = me[l-1] & eq_e[l-1-i][i];
			end
		end
	end

	res_t ld_d [NCELL];
	logic ld_v [NCELL];

	always_comb begin : step
		logic [CNT_W-1:0] total, lmax, lsel, rel, base, emc_inc, jj;
		logic             fire, close, me_sel, ematch;

		in_tool_d = in_tool_q;
		held_d    = held_q;
		emc_d     = emc_q;
		nopen_d   = nopen_q;
		jj        = '0;
		for (int j = 0; j < NCELL; j++) begin
			ld_v[j] = 1'b0;
			ld_d[j] = '0;
		end

		emc_inc = (emc_q < FMAX) ? emc_q + ONE : emc_q;
		total   = (held_q < FMAX) ? held_q + ONE : FMAX;
		lmax    = (total < slen) ? total : slen;

		// Longest held suffix that still matches a start fence prefix.
		lsel = '0;
		for (int l = 1; l <= FENCE_MAX; l++) begin
			if (CNT_W'(l) <= lmax && ms[l-1]) begin
				lsel = CNT_W'(l);
			end
		end
		rel   = total - lsel;
		fire  = (lsel == slen);
		close = fire && (rel == '0) && nopen_q;
		base  = close ? ONE : rel;

		me_sel = 1'b0;
		for (int l = 1; l <= FENCE_MAX; l++) begin
			if (CNT_W'(l) == elen) begin
				me_sel = me[l-1];
			end
		end
		ematch = (emc_inc >= elen) && me_sel;

		unique case (req_type)
			REQ_DATA: begin
				if (in_tool_q) begin
					ld_v[0] = 1'b1;
					ld_d[0] = '{data_byte, 1'b1, SEG_TOOL, ematch, 1'b0, 1'b0};
					if (ematch) begin
						in_tool_d = 1'b0;
						emc_d     = '0;
						held_d    = '0;
					end else begin
						emc_d = emc_inc;
					end
				end else begin
					for (int j = 0; j < NCELL; j++) begin
						jj = CNT_W'(j);
						if (jj < rel) begin
							ld_v[j] = 1'b1;
							ld_d[j] = '{pick(new_vec, total - ONE - jj), 1'b1, SEG_NORMAL,
							            fire && (jj == rel - ONE), 1'b0, 1'b0};
						end else if (close && j == 0) begin
							ld_v[j] = 1'b1;
							ld_d[j] = '{'0, 1'b0, SEG_NORMAL, 1'b1, 1'b0, 1'b0};
						end else if (fire && (jj - base) < slen) begin
							ld_v[j] = 1'b1;
							ld_d[j] = '{pick(new_vec, slen - ONE - (jj - base)), 1'b1, SEG_TOOL,
							            1'b0, 1'b0, 1'b0};
						end
					end
					if (rel != '0) begin
						nopen_d = 1'b1;
					end
					if (fire) begin
						nopen_d   = 1'b0;
						in_tool_d = 1'b1;
						held_d    = '0;
						emc_d     = '0;
					end else begin
						held_d = lsel;
					end
				end
			end
			REQ_CHUNK: begin
				if (!in_tool_q && nopen_q) begin
					ld_v[0] = 1'b1;
					ld_d[0] = '{'0, 1'b0, SEG_NORMAL, 1'b1, 1'b0, 1'b0};
					nopen_d = 1'b0;
				end
			end
			REQ_DONE: begin
				if (in_tool_q) begin
					ld_v[0] = 1'b1;
					ld_d[0] = '{'0, 1'b0, SEG_TOOL, 1'b1, 1'b1, 1'b0};
				end else if (held_q == '0) begin
					ld_v[0] = 1'b1;
					ld_d[0] = '{'0, 1'b0, SEG_NORMAL, nopen_q, 1'b1, 1'b0};
				end else begin
					// Flush the held bytes; the final one closes and completes.
					for (int j = 0; j < NCELL; j++) begin
						jj = CNT_W'(j);
						if (jj < held_q) begin
							ld_v[j] = 1'b1;
							ld_d[j] = '{pick(cur_vec, held_q - ONE - jj), 1'b1, SEG_NORMAL,
							            jj == held_q - ONE, jj == held_q - ONE, 1'b0};
						end
					end
				end
				in_tool_d = 1'b0;
				held_d    = '0;
				emc_d     = '0;
				nopen_d   = 1'b0;
			end
			default: begin
			end
		endcase

		for (int j = 0; j < NCELL - 1; j++) begin
			ld_d[j].last = ld_v[j] && !ld_v[j+1];
		end
		ld_d[NCELL-1].last = ld_v[NCELL-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_tool_q <= 1'b0;
			held_q    <= '0;
			emc_q     <= '0;
			nopen_q   <= 1'b0;
		end else if (req_acc) begin
			in_tool_q <= in_tool_d;
			held_q    <= held_d;
			emc_q     <= emc_d;
			nopen_q   <= nopen_d;
		end
	end

	// Result chain; cell 0 drives the output.
	for (genvar j = 0; j < NCELL; j++) begin : g_out
		logic nb_v;
		res_t nb_d;
		if (j == NCELL - 1) begin : g_tail
			assign nb_v = 1'b0;
			assign nb_d = '0;
		end else begin : g_body
			assign nb_v = cell_v[j+1];
			assign nb_d = cell_d[j+1];
		end
		cfss_out_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.load   (req_acc),
			.shift  (res_pop),
			.ld_v   (ld_v[j]),
			.ld_d   (ld_d[j]),
			.nb_v   (nb_v),
			.nb_d   (nb_d),
			.v_q    (cell_v[j]),
			.d_q    (cell_d[j])
		);
	end

	assign res_valid   = cell_v[0];
	assign out_byte    = cell_d[0].out_byte;
	assign has_byte    = cell_d[0].has_byte;
	assign seg_kind    = cell_d[0].seg_kind;
	assign seg_end     = cell_d[0].seg_end;
	assign stream_done = cell_d[0].stream_done;
	assign last        = cell_d[0].last;

	// The chain fills from the output end, so a valid slot has a valid predecessor.
	a_chain_packed: assert property (@(posedge clk) disable iff (!arst_n)
		cell_v[1] |-> cell_v[0])
		else $error("result chain has a gap");

	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_q < FMAX)
		else $error("held byte count reached the fence limit");

	a_tool_clean: assert property (@(posedge clk) disable iff (!arst_n)
		in_tool_q |-> (held_q == '0) && !nopen_q)
		else $error("tool mode with held bytes or an open normal segment");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && stream_done) |-> last)
		else $error("stream completion not on the final result");

	a_done_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && req_type == REQ_DONE) |=> !in_tool_q && held_q == '0 && emc_q == '0)
		else $error("state not cleared after end of stream");

endmodule
